// File: hdl/transition_table_word_acceptor_defines.svh
// Assertion macros used by the top level of the word acceptor.
`ifndef TRANSITION_TABLE_WORD_ACCEPTOR_DEFINES_SVH
`define TRANSITION_TABLE_WORD_ACCEPTOR_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, held off during reset.
`define TTWA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, held off during reset.
`define TTWA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ttwa_pkg.sv
// Shared types and constants of the word acceptor.
package ttwa_pkg;

    localparam int STATE_W    = 6;
    localparam int IDX_W      = 6;
    localparam int LABEL_W    = 8;
    localparam int KIND_W     = 2;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // Addressable range of the state and slot fields.
    localparam int STATE_SPACE = 2 ** STATE_W;
    localparam int SLOT_SPACE  = 2 ** IDX_W;

    localparam int DEF_MAX_TRANSITIONS = 64;
    localparam int DEF_NUM_STATES      = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS_COUNT = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        K_WR_TRANS = 2'd0,
        K_WR_FINAL = 2'd1,
        K_SYMBOL   = 2'd2,
        K_EMPTY    = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [IDX_W-1:0]    entry_index;
        logic [STATE_W-1:0]  from_state;
        logic [STATE_W-1:0]  to_state;
        logic [LABEL_W-1:0]  edge_label;
        logic                final_flag;
        logic [LABEL_W-1:0]  symbol;
        logic                first_symbol;
        logic                last_symbol;
    } t_item;

    typedef struct packed {
        logic [STATE_W-1:0] src;
        logic [STATE_W-1:0] dst;
        logic [LABEL_W-1:0] lab;
    } t_edge;

    typedef struct packed {
        logic load;      // item accepted this cycle
        logic scan;      // step the transition scan
        logic mark_rd;   // fetch the final mark
        logic out_load;  // capture the verdict into the output register
    } t_cmd;

    typedef struct packed {
        t_kind in_kind;
        logic  in_stuck;  // stuck flag as it stands once the offered item is taken
        logic  in_last;
        logic  hit;
        logic  miss_done;
        logic  last;
    } t_status;

endpackage

// File: hdl/ttwa_item_if.sv
// Input item channel of the word acceptor.
interface ttwa_item_if;
    import ttwa_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [IDX_W-1:0]    entry_index;
    logic [STATE_W-1:0]  from_state;
    logic [STATE_W-1:0]  to_state;
    logic [LABEL_W-1:0]  edge_label;
    logic                final_flag;
    logic [LABEL_W-1:0]  symbol;
    logic                first_symbol;
    logic                last_symbol;

    modport source (
        output valid, kind, entry_index, from_state, to_state, edge_label,
               final_flag, symbol, first_symbol, last_symbol,
        input  ready
    );
    modport sink (
        input  valid, kind, entry_index, from_state, to_state, edge_label,
               final_flag, symbol, first_symbol, last_symbol,
        output ready
    );
endinterface

// File: hdl/ttwa_result_if.sv
// Result item channel of the word acceptor.
interface ttwa_result_if;
    logic valid;
    logic ready;
    logic accepted;
    logic stuck;

    modport source (output valid, accepted, stuck, input ready);
    modport sink (input valid, accepted, stuck, output ready);
endinterface

// File: hdl/ttwa_cfg_if.sv
// Configuration write channel of the word acceptor.
interface ttwa_cfg_if;
    import ttwa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/ttwa_ctrl.sv
// Sequencer of the word acceptor: accept, scan, mark fetch, verdict.
module ttwa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  ttwa_pkg::t_status i_status,
    output ttwa_pkg::t_cmd    o_cmd
);
    import ttwa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    case (i_status.in_kind)
                        K_SYMBOL: begin
                            if (!i_status.in_stuck) begin
                                n_state = S_SCAN;
                            end else if (i_status.in_last) begin
                                n_state = S_MARK;
                            end
                        end
                        K_EMPTY: n_state = S_MARK;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (i_status.hit || i_status.miss_done) begin
                    n_state = i_status.last ? S_MARK : S_IDLE;
                end
            end
            S_MARK: begin
                cmd.mark_rd = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                // hold the verdict until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: hdl/ttwa_dp.sv
// Datapath of the word acceptor: transition memory, final marks, run state.
module ttwa_dp #(
    parameter int MAX_TRANSITIONS = ttwa_pkg::DEF_MAX_TRANSITIONS,
    parameter int NUM_STATES      = ttwa_pkg::DEF_NUM_STATES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ttwa_pkg::t_cmd                i_cmd,
    input  ttwa_pkg::t_item               i_item,
    input  logic [ttwa_pkg::STATE_W-1:0]  i_start_state,
    input  logic [ttwa_pkg::COUNT_W-1:0]  i_trans_count,
    output ttwa_pkg::t_status             o_status,
    output logic                          o_accepted,
    output logic                          o_stuck
);
    import ttwa_pkg::*;

    // Only slots and states that the fields can name need storage.
    localparam int TR_DEPTH  = (MAX_TRANSITIONS < SLOT_SPACE) ? MAX_TRANSITIONS : SLOT_SPACE;
    localparam int FIN_DEPTH = (NUM_STATES < STATE_SPACE) ? NUM_STATES : STATE_SPACE;
    localparam int TR_AW     = (TR_DEPTH > 1) ? $clog2(TR_DEPTH) : 1;
    localparam int FIN_AW    = $clog2(FIN_DEPTH);
    localparam int CNT_W     = $clog2(TR_DEPTH + 1);

    t_edge mem [TR_DEPTH];
    t_edge r_rdata;

    logic [FIN_DEPTH-1:0] r_marks;
    logic [STATE_W-1:0]   r_cur;
    logic                 r_stuck;
    logic [CNT_W-1:0]     r_k;
    logic                 r_pend;
    logic [LABEL_W-1:0]   r_sym;
    logic                 r_last;
    logic                 r_empty;
    logic                 r_mark;
    logic                 r_res_acc;
    logic                 r_res_stuck;

    logic [CNT_W-1:0]   limit;
    logic               issue;
    logic               hit;
    logic               miss_done;
    logic [STATE_W-1:0] mark_addr;
    logic               mark_ok;
    logic               wr_trans;
    logic               wr_final;

    // scan bound: the entry count, capped at the memory depth
    assign limit = (32'(i_trans_count) > 32'(TR_DEPTH)) ? CNT_W'(TR_DEPTH)
                                                         : CNT_W'(i_trans_count);
    assign issue     = (r_k < limit);
    assign hit       = r_pend && (r_rdata.src == r_cur) && (r_rdata.lab == r_sym);
    assign miss_done = !hit && !issue;

    assign mark_addr = r_empty ? i_start_state : r_cur;
    assign mark_ok   = (32'(mark_addr) < 32'(FIN_DEPTH));

    assign wr_trans = i_cmd.load && (i_item.kind == K_WR_TRANS) &&
                      (32'(i_item.entry_index) < 32'(TR_DEPTH));
    assign wr_final = i_cmd.load && (i_item.kind == K_WR_FINAL) &&
                      (32'(i_item.from_state) < 32'(FIN_DEPTH));

    // transition memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_trans) begin
            mem[i_item.entry_index[TR_AW-1:0]] <= '{src: i_item.from_state,
                                                    dst: i_item.to_state,
                                                    lab: i_item.edge_label};
        end
        if (i_cmd.scan && issue) begin
            r_rdata <= mem[r_k[TR_AW-1:0]];
        end
    end

    // run state and final marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks <= '0;
            r_cur   <= '0;
            r_stuck <= 1'b0;
            r_k     <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (wr_final) begin
                r_marks[i_item.from_state[FIN_AW-1:0]] <= i_item.final_flag;
            end
            if (i_cmd.load) begin
                r_k    <= '0;
                r_pend <= 1'b0;
                if (i_item.kind == K_SYMBOL && i_item.first_symbol) begin
                    r_cur   <= i_start_state;
                    r_stuck <= 1'b0;
                end
            end else if (i_cmd.scan) begin
                r_pend <= issue;
                if (issue) begin
                    r_k <= r_k + 1'b1;
                end
                if (hit) begin
                    r_cur <= r_rdata.dst;
                end else if (miss_done) begin
                    r_stuck <= 1'b1;
                end
            end
        end
    end

    // item payload and verdict
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sym   <= i_item.symbol;
            r_last  <= i_item.last_symbol;
            r_empty <= (i_item.kind == K_EMPTY);
        end
        if (i_cmd.mark_rd) begin
            r_mark <= mark_ok ? r_marks[mark_addr[FIN_AW-1:0]] : 1'b0;
        end
        if (i_cmd.out_load) begin
            r_res_acc   <= r_empty ? r_mark : (!r_stuck && r_mark);
            r_res_stuck <= r_empty ? 1'b0 : r_stuck;
        end
    end

    assign o_status = '{in_kind:   i_item.kind,
                        in_stuck:  i_item.first_symbol ? 1'b0 : r_stuck,
                        in_last:   i_item.last_symbol,
                        hit:       hit,
                        miss_done: miss_done,
                        last:      r_last};

    assign o_accepted = r_res_acc;
    assign o_stuck    = r_res_stuck;

endmodule

// File: hdl/transition_table_word_acceptor.sv
// Top level of the table-driven word acceptor.
//
// The block holds a list of transitions (from, to, label) and one final mark per
// state, and runs words through them one symbol per item. Item kinds: write a
// transition slot, write a final mark, a word symbol, an empty word. The first
// symbol of a word restarts the run at start_state; each symbol follows the
// first listed entry (slots 0 to transition_count - 1) whose source is the
// current state and whose label is the symbol, and a symbol with no match
// leaves the word stuck. The last symbol of a word, and every empty-word item,
// gives one result item: accepted and stuck. A write is done in the idle state;
// a symbol scans the entries from slot 0 until a match or the end of the list,
// one that meets a word already stuck skips the scan, and a last symbol then
// fetches the final mark and loads the verdict, as an empty word does. The scan
// reads the single transition memory port once per cycle. The result sits in an
// output register, so the next item is taken while the previous verdict waits.
// Slots must be written before a scan reaches them. Configuration writes
// (start_state at index 0, transition_count at index 1) are taken every cycle
// and are meant for an idle block.
`include "transition_table_word_acceptor_defines.svh"

module transition_table_word_acceptor #(
    parameter int MAX_TRANSITIONS = ttwa_pkg::DEF_MAX_TRANSITIONS,
    parameter int NUM_STATES      = ttwa_pkg::DEF_NUM_STATES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ttwa_item_if.sink     i_item,
    ttwa_result_if.source o_result,
    ttwa_cfg_if.sink      i_cfg
);
    import ttwa_pkg::*;

    logic [STATE_W-1:0] r_start_state;
    logic [COUNT_W-1:0] r_trans_count;

    t_item   item;
    t_cmd    cmd;
    t_status status;
    logic    in_ready;
    logic    out_valid;
    logic    res_accepted;
    logic    res_stuck;

    // configuration registers: always ready, decode the index by name
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_state <= '0;
            r_trans_count <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_START_STATE: r_start_state <= i_cfg.data[STATE_W-1:0];
                CFG_TRANS_COUNT: r_trans_count <= i_cfg.data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // gather the item fields for the datapath
    assign item = '{kind:         t_kind'(i_item.kind),
                    entry_index:  i_item.entry_index,
                    from_state:   i_item.from_state,
                    to_state:     i_item.to_state,
                    edge_label:   i_item.edge_label,
                    final_flag:   i_item.final_flag,
                    symbol:       i_item.symbol,
                    first_symbol: i_item.first_symbol,
                    last_symbol:  i_item.last_symbol};

    ttwa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_result.ready),
        .o_out_valid (out_valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ttwa_dp #(
        .MAX_TRANSITIONS (MAX_TRANSITIONS),
        .NUM_STATES      (NUM_STATES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_item        (item),
        .i_start_state (r_start_state),
        .i_trans_count (r_trans_count),
        .o_status      (status),
        .o_accepted    (res_accepted),
        .o_stuck       (res_stuck)
    );

    assign i_item.ready      = in_ready;
    assign o_result.valid    = out_valid;
    assign o_result.accepted = res_accepted;
    assign o_result.stuck    = res_stuck;

    // a stuck word is never accepted
    `TTWA_ASSERT_NOW(a_stuck_not_accepted, o_result.valid, !(o_result.accepted && o_result.stuck), "stuck word reported as accepted")
    // table writes finish in the cycle they are taken
    `TTWA_ASSERT_NEXT(a_write_one_cycle, i_item.valid && i_item.ready && (i_item.kind == K_WR_TRANS || i_item.kind == K_WR_FINAL), i_item.ready, "table write did not return to idle")
    // the scan stops at the first matching entry
    `TTWA_ASSERT_NEXT(a_scan_stops_on_hit, cmd.scan && status.hit, !cmd.scan, "scan went on past a match")

endmodule

// File: bench/testbench.sv
// Self-checking bench for the word acceptor: predicts each verdict and checks it.
module testbench;
    import ttwa_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    // Longest item: a full table scan plus the final-mark fetch and the verdict.
    localparam int SCAN_SLACK   = 80;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int ITEM_TARGET  = 1250;
    localparam int MAX_SLOTS    = DEF_MAX_TRANSITIONS;

    typedef struct packed {
        logic accepted;
        logic stuck;
    } t_verdict;

    logic i_clk;
    logic i_rst_n;

    ttwa_item_if   item_ch();
    ttwa_result_if result_ch();
    ttwa_cfg_if    cfg_ch();

    transition_table_word_acceptor dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    // Shadow copy of the automaton: table, final marks, run state, registers.
    t_edge              arc_mem    [MAX_SLOTS];
    bit                 arc_loaded [MAX_SLOTS];
    bit                 final_mark [STATE_SPACE];
    logic [STATE_W-1:0] run_state;
    bit                 run_stuck;
    logic [STATE_W-1:0] start_reg;
    logic [COUNT_W-1:0] count_reg;

    // Verdicts still owed by the block, oldest first.
    t_verdict verdict_q [$];

    int unsigned mismatches;
    int unsigned items_sent;
    int unsigned words_judged;
    int unsigned empty_words;
    int unsigned stuck_words;
    int unsigned accepted_words;
    int unsigned results_checked;

    // Sender burst shaping and receiver hold-off request.
    int unsigned burst_left;
    bit          gapless;
    bit          hold_req;
    int unsigned hold_left;
    int unsigned rx_cycle;
    int unsigned quiet_cycles;

    // Random automaton shape for the current phase.
    int unsigned        pool_base;
    int unsigned        pool_span;
    logic [LABEL_W-1:0] alphabet [4];

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Advance the shadow automaton by one accepted item; queue its verdict, if any.
    task automatic predict_item(input t_item it);
        int n;
        bit hit;
        case (it.kind)
            K_WR_TRANS: begin
                arc_mem[it.entry_index] = '{src: it.from_state, dst: it.to_state,
                                            lab: it.edge_label};
                arc_loaded[it.entry_index] = 1'b1;
            end
            K_WR_FINAL: final_mark[it.from_state] = it.final_flag;
            K_EMPTY: begin
                // Empty word judges start_state only and leaves the run alone.
                verdict_q.push_back('{accepted: final_mark[start_reg], stuck: 1'b0});
                empty_words++;
            end
            K_SYMBOL: begin
                if (it.first_symbol) begin
                    run_state = start_reg;
                    run_stuck = 1'b0;
                end
                // Once stuck, the rest of the word does not move the state.
                if (!run_stuck) begin
                    n   = (count_reg > MAX_SLOTS) ? MAX_SLOTS : count_reg;
                    hit = 1'b0;
                    for (int k = 0; k < n && !hit; k++) begin
                        if (!arc_loaded[k])
                            report_mismatch($sformatf("stimulus scans unwritten slot %0d", k));
                        else if (arc_mem[k].src == run_state && arc_mem[k].lab == it.symbol) begin
                            run_state = arc_mem[k].dst;
                            hit       = 1'b1;
                        end
                    end
                    if (!hit)
                        run_stuck = 1'b1;
                end
                if (it.last_symbol) begin
                    verdict_q.push_back('{accepted: !run_stuck && final_mark[run_state],
                                          stuck: run_stuck});
                    words_judged++;
                    if (run_stuck)
                        stuck_words++;
                    else if (final_mark[run_state])
                        accepted_words++;
                end
            end
        endcase
    endtask

    function automatic t_item random_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(t_item)-1:0];
    endfunction

    // Offer one item, hold it until taken, then advance the shadow model.
    // Valid stays high on return, so items within a burst do not drop it.
    task automatic send_item(input t_item it);
        if (!gapless && burst_left == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        item_ch.valid        <= 1'b1;
        item_ch.kind         <= it.kind;
        item_ch.entry_index  <= it.entry_index;
        item_ch.from_state   <= it.from_state;
        item_ch.to_state     <= it.to_state;
        item_ch.edge_label   <= it.edge_label;
        item_ch.final_flag   <= it.final_flag;
        item_ch.symbol       <= it.symbol;
        item_ch.first_symbol <= it.first_symbol;
        item_ch.last_symbol  <= it.last_symbol;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        items_sent++;
        predict_item(it);
    endtask

    task automatic send_arc(input int slot, input logic [STATE_W-1:0] src,
                            input logic [STATE_W-1:0] dst, input logic [LABEL_W-1:0] lab);
        t_item it;
        it             = random_item();
        it.kind        = K_WR_TRANS;
        it.entry_index = IDX_W'(slot);
        it.from_state  = src;
        it.to_state    = dst;
        it.edge_label  = lab;
        send_item(it);
    endtask

    task automatic send_mark(input logic [STATE_W-1:0] state, input bit flag);
        t_item it;
        it            = random_item();
        it.kind       = K_WR_FINAL;
        it.from_state = state;
        it.final_flag = flag;
        send_item(it);
    endtask

    task automatic send_empty();
        t_item it;
        it      = random_item();
        it.kind = K_EMPTY;
        send_item(it);
    endtask

    task automatic send_symbol(input logic [LABEL_W-1:0] sym, input bit first, input bit last);
        t_item it;
        it              = random_item();
        it.kind         = K_SYMBOL;
        it.symbol       = sym;
        it.first_symbol = first;
        it.last_symbol  = last;
        send_item(it);
    endtask

    // Mostly follow an existing transition out of the state the word will be in.
    function automatic logic [LABEL_W-1:0] pick_symbol(input bit first, input int guided_pct);
        logic [STATE_W-1:0] here;
        logic [LABEL_W-1:0] choices [$];
        int n;
        here = first ? start_reg : run_state;
        n    = (count_reg > MAX_SLOTS) ? MAX_SLOTS : count_reg;
        if (first || !run_stuck) begin
            for (int k = 0; k < n; k++)
                if (arc_loaded[k] && arc_mem[k].src == here)
                    choices.push_back(arc_mem[k].lab);
        end
        if (choices.size() > 0 && $urandom_range(0, 99) < guided_pct)
            return choices[$urandom_range(0, choices.size() - 1)];
        return LABEL_W'($urandom);
    endfunction

    task automatic send_word(input int len, input int guided_pct);
        bit first;
        for (int i = 0; i < len; i++) begin
            first = (i == 0);
            send_symbol(pick_symbol(first, guided_pct), first, i == len - 1);
        end
    endtask

    function automatic int word_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
    endfunction

    function automatic logic [STATE_W-1:0] pool_state();
        return STATE_W'(pool_base + $urandom_range(0, pool_span - 1));
    endfunction

    function automatic logic [LABEL_W-1:0] pool_label();
        if ($urandom_range(0, 9) == 0)
            return LABEL_W'($urandom);
        return alphabet[$urandom_range(0, 3)];
    endfunction

    task automatic new_pool();
        case ($urandom_range(0, 3))
            0: pool_span = 3;
            1: pool_span = 6;
            2: pool_span = 12;
            default: pool_span = STATE_SPACE;
        endcase
        pool_base = $urandom_range(0, STATE_SPACE - 1);
        foreach (alphabet[i])
            alphabet[i] = LABEL_W'($urandom);
    endtask

    // Drop valid, wait for every owed verdict, then let a last scan run out.
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (SCAN_SLACK) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx == CFG_START_STATE)
            start_reg = data[STATE_W-1:0];
        else
            count_reg = data;
    endtask

    // Call only on an idle block; the spare top bit of start_state is randomized.
    task automatic set_config(input logic [STATE_W-1:0] start_val,
                              input logic [COUNT_W-1:0] count_val);
        write_reg(CFG_START_STATE, {1'($urandom), start_val});
        write_reg(CFG_TRANS_COUNT, count_val);
        cfg_ch.valid <= 1'b0;
    endtask

    // Empty word and a continued symbol straight out of reset.
    task automatic test_reset_defaults();
        send_empty();
        send_arc(0, 6'd0, 6'd63, 8'hFF);
        send_arc(1, 6'd0, 6'd5, 8'h00);
        send_mark(6'd63, 1'b1);
        settle();
        set_config(6'd0, 7'd2);
        // No first symbol: the run continues from state 0, not stuck.
        send_symbol(8'hFF, 1'b0, 1'b1);
    endtask

    // Two entries share source and label; the lower slot must win.
    task automatic test_first_match();
        send_arc(2, 6'd63, 6'd10, 8'h41);
        send_arc(3, 6'd63, 6'd20, 8'h41);
        send_mark(6'd20, 1'b1);
        settle();
        set_config(6'd0, 7'd4);
        send_symbol(8'hFF, 1'b1, 1'b0);
        send_symbol(8'h41, 1'b0, 1'b1);
    endtask

    // A miss sticks the word for good; an empty word mid-run leaves the run alone.
    task automatic test_stuck_words();
        send_symbol(8'hFF, 1'b1, 1'b0);
        send_symbol(8'h99, 1'b0, 1'b0);
        send_symbol(8'hFF, 1'b0, 1'b1);
        send_symbol(8'hFF, 1'b1, 1'b0);
        send_empty();
        send_symbol(8'h41, 1'b0, 1'b1);
    endtask

    // Empty table sticks every word; the top start state is final here.
    task automatic test_config_extremes();
        settle();
        set_config(6'd63, 7'd0);
        send_symbol(8'h00, 1'b1, 1'b1);
        send_empty();
    endtask

    task automatic test_final_mark_clear();
        send_mark(6'd63, 1'b0);
        send_empty();
    endtask

    // Load every slot, so any count is safe from here on.
    task automatic test_table_fill();
        new_pool();
        for (int slot = 0; slot < MAX_SLOTS; slot++)
            send_arc(slot, pool_state(), pool_state(), pool_label());
        repeat (6) send_mark(pool_state(), 1'b1);
        settle();
        set_config(pool_state(), 7'(MAX_SLOTS));
        repeat (20) send_word(word_len(), 90);
    endtask

    // Counts past the table size scan the whole table and no further.
    task automatic test_count_overflow();
        settle();
        set_config(pool_state(), 7'h7F);
        send_arc(MAX_SLOTS - 1, start_reg, pool_state(), 8'hA5);
        repeat (5) send_symbol(8'hA5, 1'b1, 1'b1);
        repeat (12) send_word(word_len(), 85);
    endtask

    task automatic test_random_automata();
        int unsigned phase_end;
        int unsigned pick;
        logic [COUNT_W-1:0] cnt;
        while (items_sent < ITEM_TARGET) begin
            settle();
            new_pool();
            repeat ($urandom_range(8, 32))
                send_arc($urandom_range(0, MAX_SLOTS - 1), pool_state(), pool_state(),
                         pool_label());
            repeat ($urandom_range(2, 8)) send_mark(pool_state(), $urandom_range(0, 3) != 0);
            settle();
            case ($urandom_range(0, 9))
                0: cnt = '0;
                1, 2: cnt = COUNT_W'($urandom_range(1, 16));
                3, 4, 5: cnt = COUNT_W'($urandom_range(17, MAX_SLOTS - 1));
                6, 7: cnt = COUNT_W'(MAX_SLOTS);
                default: cnt = COUNT_W'($urandom_range(MAX_SLOTS + 1, 127));
            endcase
            set_config(($urandom_range(0, 4) == 0) ? STATE_W'($urandom) : pool_state(), cnt);
            gapless   = ($urandom_range(0, 3) == 0);
            phase_end = items_sent + $urandom_range(80, 160);
            while (items_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 78)
                    send_word(word_len(), 85);
                else if (pick < 86)
                    send_item(random_item());
                else if (pick < 92)
                    send_empty();
                else if (pick < 96)
                    send_word(word_len(), 30);
                else
                    // Broken word: carry on from wherever the last run stopped.
                    send_symbol(pick_symbol(1'b0, 70), 1'b0, 1'($urandom_range(0, 1)));
            end
            gapless = 1'b0;
        end
    endtask

    // Stall the result side while items keep coming, so the input backs up.
    task automatic test_output_backpressure();
        gapless  = 1'b1;
        hold_req = 1'b1;
        repeat (24) begin
            if ($urandom_range(0, 3) == 0)
                send_empty();
            else
                send_word(1, 80);
        end
        gapless = 1'b0;
    endtask

    // Pause the sender until the block owes nothing, then resume.
    task automatic test_drain_pause();
        repeat (8) send_word(word_len(), 85);
        settle();
        repeat (8) send_word(word_len(), 85);
    endtask

    // Result side: after any hold-off, ready follows one of four patterns picked by rx_cycle[9:8].
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            result_ch.ready <= 1'b0;
            hold_left--;
        end else begin
            case (rx_cycle[9:8])
                2'd0: result_ch.ready <= 1'b1;
                2'd1: result_ch.ready <= 1'($urandom_range(0, 1));
                2'd2: result_ch.ready <= (rx_cycle[1:0] == 2'd0);
                default: result_ch.ready <= (rx_cycle[5:3] != 3'd0);
            endcase
        end
        rx_cycle++;
    end

    // Compare every taken verdict with the oldest owed one.
    always @(posedge i_clk) begin : check_verdict
        t_verdict want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            results_checked++;
            if (verdict_q.size() == 0) begin
                report_mismatch("verdict arrived with no word pending");
            end else begin
                want = verdict_q.pop_front();
                if (result_ch.accepted !== want.accepted)
                    report_mismatch($sformatf("accepted %b, expected %b",
                                              result_ch.accepted, want.accepted));
                if (result_ch.stuck !== want.stuck)
                    report_mismatch($sformatf("stuck %b, expected %b",
                                              result_ch.stuck, want.stuck));
            end
        end
    end

    // Watchdog: end the run if no channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready) ||
            (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d verdicts owed",
                     STALL_LIMIT, verdict_q.size());
            $display("** transition_table_word_acceptor: FAILED **");
            $finish;
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.kind         = '0;
        item_ch.entry_index  = '0;
        item_ch.from_state   = '0;
        item_ch.to_state     = '0;
        item_ch.edge_label   = '0;
        item_ch.final_flag   = 1'b0;
        item_ch.symbol       = '0;
        item_ch.first_symbol = 1'b0;
        item_ch.last_symbol  = 1'b0;
        result_ch.ready      = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        foreach (arc_loaded[i])
            arc_loaded[i] = 1'b0;
        foreach (final_mark[i])
            final_mark[i] = 1'b0;
        run_state = '0;
        run_stuck = 1'b0;
        start_reg = '0;
        count_reg = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_first_match();
        test_stuck_words();
        test_config_extremes();
        test_final_mark_clear();
        test_table_fill();
        test_count_overflow();
        test_output_backpressure();
        test_drain_pause();
        test_random_automata();
        test_output_backpressure();

        settle();
        $display("run: %0d items, %0d words judged (%0d stuck, %0d accepted), %0d empty words",
                 items_sent, words_judged, stuck_words, accepted_words, empty_words);
        $display("run: %0d verdicts checked, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("** transition_table_word_acceptor: PASSED **");
        else
            $display("** transition_table_word_acceptor: FAILED **");
        $finish;
    end

endmodule
